/* rtl/core/mlrq_pkg.sv */
package mlrq_pkg;

    localparam int NUM_TASKS  = 64;
    localparam int NUM_LEVELS = 16;
    localparam int NUM_CPUS   = 4;
    localparam int QPL        = NUM_CPUS + 1;
    localparam int NUM_QUEUES = NUM_LEVELS * QPL;

    // The task index is taken from the low bits of the request, so the task
    // count is kept a power of two.
    localparam int TASK_W  = $clog2(NUM_TASKS);
    localparam int LINK_W  = TASK_W + 1;
    localparam int QID_W   = $clog2(NUM_QUEUES);
    localparam int LVL_W   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SLICE_W = 23;
    localparam int TICKS_W = 16;
    localparam int QUANT_W = 7;

    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_TASKS);

    localparam logic [QUANT_W-1:0] QUANTUM_TAB [16] = '{
        7'd50, 7'd50, 7'd20, 7'd20, 7'd10, 7'd10, 7'd10, 7'd5,
        7'd5,  7'd5,  7'd5,  7'd5,  7'd5,  7'd5,  7'd5,  7'd5
    };
    localparam logic [QUANT_W-1:0] QUANTUM_DEFAULT = 7'd100;

    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_ERASE      = 2'd2,
        CMD_PICK       = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_EMPTY      = 3'd1,
        STS_BAD_PRIO   = 3'd2,
        STS_QUEUED     = 3'd3,
        STS_NOT_QUEUED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PICK_HEAD,
        S_UNLINK,
        S_SLICE,
        S_FRONT_1,
        S_FRONT_2,
        S_BACK_1,
        S_BACK_2
    } t_state;

    // Classified request as it travels from the front part to the back part.
    typedef struct packed {
        t_cmd              cmd;
        logic [TASK_W-1:0] task_id;
        logic [7:0]        prio;
        logic              prio_ok;
        logic [QID_W-1:0]  qid;
        logic [LVL_W-1:0]  top;
        logic              cpu_ok;
        logic [1:0]        cpu;
    } t_req;

    function automatic logic [QUANT_W-1:0] quantum(input logic [7:0] p);
        logic [QUANT_W-1:0] q;
        if (p < 8'd16) begin
            q = QUANTUM_TAB[p[3:0]];
        end else begin
            q = QUANTUM_DEFAULT;
        end
        return q;
    endfunction

endpackage

/* rtl/core/mlrq_front.sv */
module mlrq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  logic [1:0]     i_cmd,
    input  logic [5:0]     i_task_id,
    input  logic [7:0]     i_priority_req,
    input  logic [2:0]     i_affinity,
    input  logic [1:0]     i_cpu,
    input  logic [7:0]     i_pick_limit,
    output mlrq_pkg::t_req o_req,
    output logic           o_req_vld,
    input  logic           i_req_pop
);
    import mlrq_pkg::*;

    t_req              req_in;
    logic [2:0]        sub;
    logic              push;
    logic              pop;
    t_req              r_fifo [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wp;
    logic [FPTR_W-1:0] r_rp;
    logic [FCNT_W-1:0] r_cnt;
    logic [FPTR_W-1:0] n_wp;
    logic [FPTR_W-1:0] n_rp;
    logic [FCNT_W-1:0] n_cnt;

    // Affinity beyond the last cpu falls back to the global queue.
    always_comb begin
        sub = (32'(i_affinity) <= NUM_CPUS) ? i_affinity : 3'd0;
        req_in.cmd     = t_cmd'(i_cmd);
        req_in.task_id = i_task_id[TASK_W-1:0];
        req_in.prio    = i_priority_req;
        req_in.prio_ok = 32'(i_priority_req) < NUM_LEVELS;
        req_in.qid     = QID_W'(32'(i_priority_req[LVL_W-1:0]) * QPL + 32'(sub));
        req_in.top     = (32'(i_pick_limit) > NUM_LEVELS - 1) ? LVL_W'(NUM_LEVELS - 1)
                                                            : i_pick_limit[LVL_W-1:0];
        req_in.cpu_ok  = 32'(i_cpu) < NUM_CPUS;
        req_in.cpu     = i_cpu;
    end

    assign o_busy    = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_req_vld = (r_cnt != '0);
    assign o_req     = r_fifo[r_rp];
    assign push      = i_start && !o_busy;
    assign pop       = i_req_pop && o_req_vld;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (32'(r_wp) == FIFO_DEPTH - 1) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (32'(r_rp) == FIFO_DEPTH - 1) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= req_in;
        end
    end

endmodule

/* rtl/core/mlrq_back.sv */
module mlrq_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [15:0]             i_cfg_wdata,
    input  mlrq_pkg::t_req          i_req,
    input  logic                    i_req_vld,
    output logic                    o_req_pop,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic                    o_found,
    output logic [5:0]              o_picked_task,
    output logic [22:0]             o_slice_ticks
);
    import mlrq_pkg::*;

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    logic [LVL_W-1:0]     r_lv, n_lv;
    logic [TASK_W-1:0]    r_tid, n_tid;
    logic [TICKS_W-1:0]   r_ticks;
    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic                 r_found, n_found;
    logic [TASK_W-1:0]    r_task, n_task;
    logic [SLICE_W-1:0]   r_slice, n_slice;

    logic [NUM_TASKS-1:0]  r_queued;
    logic [NUM_QUEUES-1:0] r_nonempty;

    logic [LINK_W-1:0] mem_next [NUM_TASKS];
    logic [LINK_W-1:0] mem_prev [NUM_TASKS];
    logic [QID_W-1:0]  mem_qid  [NUM_TASKS];
    logic [7:0]        mem_prio [NUM_TASKS];
    logic [LINK_W-1:0] mem_head [NUM_QUEUES];
    logic [LINK_W-1:0] mem_tail [NUM_QUEUES];

    logic [LINK_W-1:0] r_next_rd, r_prev_rd, r_head_rd, r_tail_rd;
    logic [QID_W-1:0]  r_qid_rd;
    logic [7:0]        r_prio_rd;

    logic              lnk_re, head_re, tail_re;
    logic [TASK_W-1:0] lnk_ra;
    logic [QID_W-1:0]  head_ra, tail_ra;

    logic              next_we, prev_we, qid_we, prio_we, head_we, tail_we;
    logic [TASK_W-1:0] next_wa, prev_wa, qid_wa, prio_wa;
    logic [LINK_W-1:0] next_wd, prev_wd, head_wd, tail_wd;
    logic [QID_W-1:0]  qid_wd, head_wa, tail_wa;
    logic [7:0]        prio_wd;

    logic              q_set, q_clr, ne_set, ne_clr;
    logic [TASK_W-1:0] q_set_idx, q_clr_idx;
    logic [QID_W-1:0]  ne_set_idx, ne_clr_idx;

    logic [QID_W-1:0]   qid_loc, qid_glb;
    logic               hit_loc, hit_glb;
    logic [LINK_W-1:0]  tid_link;
    logic [SLICE_W-1:0] quant_x, ticks_x;

    always_comb begin
        qid_loc  = QID_W'(32'(r_lv) * QPL + 32'(r_req.cpu) + 1);
        qid_glb  = QID_W'(32'(r_lv) * QPL);
        hit_loc  = r_req.cpu_ok && r_nonempty[qid_loc];
        hit_glb  = r_nonempty[qid_glb];
        tid_link = LINK_W'(r_req.task_id);
        quant_x  = SLICE_W'(quantum(r_prio_rd));
        ticks_x  = SLICE_W'(r_ticks);
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_lv     = r_lv;
        n_tid    = r_tid;
        n_done   = 1'b0;
        n_status = r_status;
        n_found  = r_found;
        n_task   = r_task;
        n_slice  = r_slice;
        o_req_pop = 1'b0;
        lnk_re  = 1'b0; lnk_ra  = r_tid;
        head_re = 1'b0; head_ra = r_req.qid;
        tail_re = 1'b0; tail_ra = r_req.qid;
        next_we = 1'b0; next_wa = r_req.task_id; next_wd = NIL;
        prev_we = 1'b0; prev_wa = r_req.task_id; prev_wd = NIL;
        qid_we  = 1'b0; qid_wa  = r_req.task_id; qid_wd  = r_req.qid;
        prio_we = 1'b0; prio_wa = r_req.task_id; prio_wd = r_req.prio;
        head_we = 1'b0; head_wa = r_req.qid;     head_wd = tid_link;
        tail_we = 1'b0; tail_wa = r_req.qid;     tail_wd = tid_link;
        q_set  = 1'b0; q_set_idx  = r_req.task_id;
        q_clr  = 1'b0; q_clr_idx  = r_tid;
        ne_set = 1'b0; ne_set_idx = r_req.qid;
        ne_clr = 1'b0; ne_clr_idx = r_qid_rd;

        case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    o_req_pop = 1'b1;
                    n_req     = i_req;
                    n_tid     = i_req.task_id;
                    n_lv      = '0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_found = 1'b0;
                n_task  = '0;
                n_slice = '0;
                n_status = STS_OK;
                case (r_req.cmd)
                    CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                        if (r_queued[r_req.task_id]) begin
                            n_status = STS_QUEUED;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            prio_we = 1'b1;
                            if (!r_req.prio_ok) begin
                                n_status = STS_BAD_PRIO;
                                n_done   = 1'b1;
                                n_state  = S_IDLE;
                            end else if (!r_nonempty[r_req.qid]) begin
                                // Empty queue: the task becomes both ends.
                                head_we = 1'b1;
                                tail_we = 1'b1;
                                next_we = 1'b1;
                                prev_we = 1'b1;
                                qid_we  = 1'b1;
                                q_set   = 1'b1;
                                ne_set  = 1'b1;
                                n_done  = 1'b1;
                                n_state = S_IDLE;
                            end else if (r_req.cmd == CMD_PUSH_FRONT) begin
                                head_re = 1'b1;
                                n_state = S_FRONT_1;
                            end else begin
                                tail_re = 1'b1;
                                n_state = S_BACK_1;
                            end
                        end
                    end
                    CMD_ERASE: begin
                        if (!r_queued[r_req.task_id]) begin
                            n_status = STS_NOT_QUEUED;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            lnk_re  = 1'b1;
                            lnk_ra  = r_req.task_id;
                            n_state = S_UNLINK;
                        end
                    end
                    CMD_PICK: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (hit_loc || hit_glb) begin
                    head_re = 1'b1;
                    head_ra = hit_loc ? qid_loc : qid_glb;
                    n_state = S_PICK_HEAD;
                end else if (r_lv == r_req.top) begin
                    n_status = STS_EMPTY;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_lv = r_lv + 1'b1;
                end
            end
            S_PICK_HEAD: begin
                lnk_re  = 1'b1;
                lnk_ra  = r_head_rd[TASK_W-1:0];
                n_tid   = r_head_rd[TASK_W-1:0];
                n_state = S_UNLINK;
            end
            S_UNLINK: begin
                if (r_prev_rd != NIL) begin
                    next_we = 1'b1;
                    next_wa = r_prev_rd[TASK_W-1:0];
                    next_wd = r_next_rd;
                end else begin
                    head_we = 1'b1;
                    head_wa = r_qid_rd;
                    head_wd = r_next_rd;
                end
                if (r_next_rd != NIL) begin
                    prev_we = 1'b1;
                    prev_wa = r_next_rd[TASK_W-1:0];
                    prev_wd = r_prev_rd;
                end else begin
                    tail_we = 1'b1;
                    tail_wa = r_qid_rd;
                    tail_wd = r_prev_rd;
                end
                ne_clr = (r_prev_rd == NIL) && (r_next_rd == NIL);
                q_clr  = 1'b1;
                if (r_req.cmd == CMD_PICK) begin
                    n_state = S_SLICE;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SLICE: begin
                n_found = 1'b1;
                n_task  = r_tid;
                n_slice = quant_x * ticks_x;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_FRONT_1: begin
                next_we = 1'b1;
                next_wd = r_head_rd;
                prev_we = 1'b1;
                head_we = 1'b1;
                qid_we  = 1'b1;
                q_set   = 1'b1;
                n_state = S_FRONT_2;
            end
            S_FRONT_2: begin
                prev_we = 1'b1;
                prev_wa = r_head_rd[TASK_W-1:0];
                prev_wd = tid_link;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_BACK_1: begin
                next_we = 1'b1;
                next_wa = r_tail_rd[TASK_W-1:0];
                next_wd = tid_link;
                tail_we = 1'b1;
                qid_we  = 1'b1;
                q_set   = 1'b1;
                n_state = S_BACK_2;
            end
            S_BACK_2: begin
                prev_we = 1'b1;
                prev_wd = r_tail_rd;
                next_we = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_ticks    <= TICKS_W'(1);
            r_queued   <= '0;
            r_nonempty <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_ticks <= i_cfg_wdata;
            end
            if (q_set) begin
                r_queued[q_set_idx] <= 1'b1;
            end
            if (q_clr) begin
                r_queued[q_clr_idx] <= 1'b0;
            end
            if (ne_set) begin
                r_nonempty[ne_set_idx] <= 1'b1;
            end
            if (ne_clr) begin
                r_nonempty[ne_clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_lv     <= n_lv;
        r_tid    <= n_tid;
        r_status <= n_status;
        r_found  <= n_found;
        r_task   <= n_task;
        r_slice  <= n_slice;
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            mem_next[next_wa] <= next_wd;
        end
        if (prev_we) begin
            mem_prev[prev_wa] <= prev_wd;
        end
        if (qid_we) begin
            mem_qid[qid_wa] <= qid_wd;
        end
        if (prio_we) begin
            mem_prio[prio_wa] <= prio_wd;
        end
        if (head_we) begin
            mem_head[head_wa] <= head_wd;
        end
        if (tail_we) begin
            mem_tail[tail_wa] <= tail_wd;
        end
        if (lnk_re) begin
            r_next_rd <= mem_next[lnk_ra];
            r_prev_rd <= mem_prev[lnk_ra];
            r_qid_rd  <= mem_qid[lnk_ra];
            r_prio_rd <= mem_prio[lnk_ra];
        end
        if (head_re) begin
            r_head_rd <= mem_head[head_ra];
        end
        if (tail_re) begin
            r_tail_rd <= mem_tail[tail_ra];
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_picked_task = 6'(r_task);
    assign o_slice_ticks = r_slice;

endmodule

/* rtl/core/multilevel_ready_queue_scheduler.sv */
// Multilevel ready-queue scheduler.
// A request is issued by raising start with the command fields while busy is
// low; it is taken at that clock edge. Commands are push back, push front,
// erase and pick. Each request produces exactly one result, shown on the
// o_ result ports for a single cycle while o_done is high. The receiver
// cannot stall; a result must be captured in that cycle.
// A two-entry request queue sits between the classifying front end and the
// execution engine, so a new request is taken while an older one runs.
// busy is high only while that queue is full.
// With the engine idle, a rejected command or a push into an empty queue ends
// in the decode state; an erase adds an unlink step, a push into a non-empty
// queue two link-update steps, and a pick scans level by level up to its
// clipped limit and, on a hit, reads the head, unlinks and computes the slice.
// One request runs at a time; the next is taken in the cycle o_done is high.
// Reset clears the request queue, the queued and non-empty flags, and sets
// ticks_per_ms to 1. The link memories need no clearing. i_cfg_we writes
// ticks_per_ms; write it only while no request is in flight.
module multilevel_ready_queue_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [2:0]  i_affinity,
    input  logic [1:0]  i_cpu,
    input  logic [7:0]  i_pick_limit,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic        o_found,
    output logic [5:0]  o_picked_task,
    output logic [22:0] o_slice_ticks
);
    import mlrq_pkg::*;

    t_req req;
    logic req_vld;
    logic req_pop;

    // Front end: classifies each request and queues it.
    mlrq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cmd          (i_cmd),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .i_affinity     (i_affinity),
        .i_cpu          (i_cpu),
        .i_pick_limit   (i_pick_limit),
        .o_req          (req),
        .o_req_vld      (req_vld),
        .i_req_pop      (req_pop)
    );

    // Back end: walks and updates the linked lists and computes the slice.
    mlrq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req         (req),
        .i_req_vld     (req_vld),
        .o_req_pop     (req_pop),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_picked_task (o_picked_task),
        .o_slice_ticks (o_slice_ticks)
    );

endmodule

/* tb/multilevel_ready_queue_scheduler_checker.sv */
module multilevel_ready_queue_scheduler_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [2:0]  i_affinity,
    input  logic [1:0]  i_cpu,
    input  logic [7:0]  i_pick_limit,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_done,
    input  logic [2:0]  i_status,
    input  logic        i_found,
    input  logic [5:0]  i_picked_task,
    input  logic [22:0] i_slice_ticks,
    output int          o_fail_count,
    output int          o_pending
);
    import mlrq_pkg::*;

    localparam int NO_TASK = NUM_TASKS;
    localparam int OFF_QUEUE = NUM_QUEUES;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [5:0]  task_id;
        logic [22:0] slice;
    } t_outcome;

    int       nxt [NUM_TASKS];
    int       prv [NUM_TASKS];
    int       home_q [NUM_TASKS];
    int       prio_of [NUM_TASKS];
    int       head [NUM_QUEUES];
    int       tail [NUM_QUEUES];
    int       ticks;
    // Ring of predicted results; at most three requests are ever outstanding.
    t_outcome outcomes_due [8];
    int       n_issued;
    int       n_checked;

    function automatic void detach(int t);
        int q;
        q = home_q[t];
        if (q >= OFF_QUEUE) return;
        if (prv[t] < NO_TASK) nxt[prv[t]] = nxt[t]; else head[q] = nxt[t];
        if (nxt[t] < NO_TASK) prv[nxt[t]] = prv[t]; else tail[q] = prv[t];
        prv[t] = NO_TASK;
        nxt[t] = NO_TASK;
        home_q[t] = OFF_QUEUE;
    endfunction

    function automatic void attach(int t, int q, bit at_front);
        int h;
        h = head[q];
        if (h >= NO_TASK) begin
            head[q] = t;
            tail[q] = t;
            prv[t] = NO_TASK;
            nxt[t] = NO_TASK;
        end else if (at_front) begin
            nxt[t] = h;
            prv[t] = NO_TASK;
            prv[h] = t;
            head[q] = t;
        end else begin
            nxt[tail[q]] = t;
            prv[t] = tail[q];
            nxt[t] = NO_TASK;
            tail[q] = t;
        end
        home_q[t] = q;
    endfunction

    // Applies one request to the shadow queues and returns its result.
    function automatic t_outcome schedule(t_cmd c, int t, int p, int aff, int cpu, int lim);
        t_outcome r;
        int top;
        int got;
        r = '0;
        if (c == CMD_PUSH_BACK || c == CMD_PUSH_FRONT) begin
            if (home_q[t] < OFF_QUEUE) begin
                r.status = STS_QUEUED;
            end else begin
                prio_of[t] = p;
                if (p >= NUM_LEVELS) begin
                    r.status = STS_BAD_PRIO;
                end else begin
                    attach(t, p * QPL + ((aff <= NUM_CPUS) ? aff : 0), c == CMD_PUSH_FRONT);
                end
            end
        end else if (c == CMD_ERASE) begin
            if (home_q[t] >= OFF_QUEUE) r.status = STS_NOT_QUEUED;
            else detach(t);
        end else begin
            top = (lim > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : lim;
            got = NO_TASK;
            for (int lv = 0; lv <= top && got >= NO_TASK; lv++) begin
                if (cpu < NUM_CPUS) begin
                    got = head[lv * QPL + cpu + 1];
                    if (got < NO_TASK) detach(got);
                end
                if (got >= NO_TASK) begin
                    got = head[lv * QPL];
                    if (got < NO_TASK) detach(got);
                end
            end
            if (got < NO_TASK) begin
                r.found = 1'b1;
                r.task_id = got[5:0];
                r.slice = 23'((prio_of[got] < 16 ? QUANTUM_TAB[prio_of[got]] : 100) * ticks);
            end else begin
                r.status = STS_EMPTY;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        n_issued = 0;
        n_checked = 0;
        ticks = 1;
        for (int i = 0; i < NUM_TASKS; i++) begin
            nxt[i] = NO_TASK;
            prv[i] = NO_TASK;
            home_q[i] = OFF_QUEUE;
            prio_of[i] = 0;
        end
        for (int i = 0; i < NUM_QUEUES; i++) begin
            head[i] = NO_TASK;
            tail[i] = NO_TASK;
        end
    end

    assign o_pending = n_issued - n_checked;

    // Results are checked before new requests are predicted; an accepted
    // request cannot complete in the same edge, so the order is safe.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (i_done) begin
                if (n_issued == n_checked) begin
                    report_mismatch("unexpected result count", 1, 0);
                end else begin
                    want = outcomes_due[n_checked[2:0]];
                    n_checked++;
                    if (i_status !== want.status) report_mismatch("status", i_status, want.status);
                    if (i_found !== want.found) report_mismatch("found", i_found, want.found);
                    if (i_picked_task !== want.task_id)
                        report_mismatch("picked_task", i_picked_task, want.task_id);
                    if (i_slice_ticks !== want.slice)
                        report_mismatch("slice_ticks", i_slice_ticks, want.slice);
                end
            end
            if (i_cfg_we) ticks = i_cfg_wdata;
            if (i_start && !i_busy) begin
                outcomes_due[n_issued[2:0]] = schedule(t_cmd'(i_cmd), i_task_id,
                                                       i_priority_req, i_affinity, i_cpu,
                                                       i_pick_limit);
                n_issued++;
            end
        end
    end

endmodule

/* tb/multilevel_ready_queue_scheduler_tb.sv */
// Testbench for the multilevel ready-queue scheduler. This top only makes
// stimulus and gives the verdict; the checker beside the block predicts every
// result and compares it.
module multilevel_ready_queue_scheduler_tb;
    import mlrq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [5:0]  i_task_id = '0;
    logic [7:0]  i_priority_req = '0;
    logic [2:0]  i_affinity = '0;
    logic [1:0]  i_cpu = '0;
    logic [7:0]  i_pick_limit = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic        o_found;
    logic [5:0]  o_picked_task;
    logic [22:0] o_slice_ticks;
    int          fail_count;
    int          pending;
    int          gap_pct;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    multilevel_ready_queue_scheduler i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cmd, .i_task_id, .i_priority_req,
        .i_affinity, .i_cpu, .i_pick_limit, .i_cfg_we, .i_cfg_wdata,
        .o_done, .o_status, .o_found, .o_picked_task, .o_slice_ticks
    );

    multilevel_ready_queue_scheduler_checker i_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cmd, .i_task_id,
        .i_priority_req, .i_affinity, .i_cpu, .i_pick_limit, .i_cfg_we, .i_cfg_wdata,
        .i_done(o_done), .i_status(o_status), .i_found(o_found),
        .i_picked_task(o_picked_task), .i_slice_ticks(o_slice_ticks),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Issues one request and waits until the block takes it. Before raising
    // start the sender may idle for a while, at the current idle rate. Start
    // stays high from one request straight into the next when no gap falls.
    task automatic issue(t_cmd c, int t, int p, int aff, int cpu, int lim);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        i_task_id <= t[5:0];
        i_priority_req <= p[7:0];
        i_affinity <= aff[2:0];
        i_cpu <= cpu[1:0];
        i_pick_limit <= lim[7:0];
        do @(posedge i_clk); while (busy);
    endtask

    // Lets every outstanding request finish, then waits out the longest pick.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_ticks(logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A random request. Pushes mostly use valid levels so the queues fill up;
    // erase and pick then find real work. A few use out-of-range values.
    task automatic random_request();
        int r;
        int p;
        r = $urandom_range(99);
        p = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(NUM_LEVELS - 1);
        if (r < 50) begin
            issue(($urandom_range(1) == 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                  $urandom_range(63), p, $urandom_range(7), $urandom_range(3),
                  $urandom_range(255));
        end else if (r < 68) begin
            issue(CMD_ERASE, $urandom_range(63), $urandom_range(255), $urandom_range(7),
                  $urandom_range(3), $urandom_range(255));
        end else begin
            issue(CMD_PICK, $urandom_range(63), $urandom_range(255), $urandom_range(7),
                  $urandom_range(3),
                  ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15));
        end
    endtask

    initial begin
        gap_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pick, every command, the status codes, bad
        // affinity, cpu search order, limit clipping and priorities at both
        // ends of the range.
        issue(CMD_PICK, 0, 0, 0, 0, 255);
        issue(CMD_ERASE, 5, 0, 0, 0, 0);
        issue(CMD_PUSH_BACK, 63, 255, 7, 3, 0);
        issue(CMD_PUSH_BACK, 1, 0, 0, 0, 0);
        issue(CMD_PUSH_BACK, 1, 3, 0, 0, 0);
        issue(CMD_PUSH_FRONT, 2, 0, 0, 0, 0);
        issue(CMD_PUSH_BACK, 3, 0, 4, 0, 0);
        issue(CMD_PUSH_BACK, 4, 15, 7, 0, 0);
        issue(CMD_PUSH_BACK, 5, 15, 1, 0, 0);
        issue(CMD_PUSH_FRONT, 0, 7, 2, 0, 0);
        issue(CMD_PICK, 0, 0, 0, 3, 0);
        issue(CMD_PICK, 0, 0, 0, 0, 0);
        issue(CMD_ERASE, 1, 0, 0, 0, 0);
        issue(CMD_ERASE, 1, 0, 0, 0, 0);
        issue(CMD_PICK, 0, 0, 0, 0, 6);
        issue(CMD_PICK, 0, 0, 0, 1, 7);
        issue(CMD_PICK, 0, 0, 0, 0, 255);
        issue(CMD_PICK, 0, 0, 0, 0, 200);
        issue(CMD_PICK, 0, 0, 0, 0, 255);
        drain();

        // Random phases at several tick rates, the extremes included.
        set_ticks(16'hFFFF);
        gap_pct = 27;
        repeat (280) random_request();
        drain();
        set_ticks(16'd0);
        gap_pct = 88;
        repeat (280) random_request();
        drain();
        set_ticks(16'($urandom_range(65535)));
        gap_pct = 0;
        repeat (150) random_request();
        drain();
        set_ticks(16'd1);
        repeat (140) random_request();
        drain();

        if (fail_count == 0) begin
            $display("multilevel_ready_queue_scheduler_tb passed");
        end else begin
            $display("multilevel_ready_queue_scheduler_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("multilevel_ready_queue_scheduler_tb failed");
        $finish;
    end

endmodule
